// ----- rtl/quoted_token_lexer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quoted token lexer
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_LEXER_UNIT_MACROS_SVH
`define QUOTED_TOKEN_LEXER_UNIT_MACROS_SVH

// The property must hold at every rising edge of clk_i.
`define QTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define QTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qtl_pkg.sv -----
// ----------------------------------------------------------------------------
// qtl_pkg
// Types and constants shared by the quoted token lexer modules.
// ----------------------------------------------------------------------------
package qtl_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned BYTES_W = 16;
  localparam int unsigned MODE_W  = 3;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_STRING  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WORD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SPACE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd5;

  // Lexer state codes.
  localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CR   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WS   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WORD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ESC  = 3'd5;

  // Character codes.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSL   = 8'h5c;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTES_W-1:0] bytes;
    logic               last;
  } qtl_token_t;

  // Up to two tokens per input item, first one in tok0.
  typedef struct packed {
    logic [1:0] cnt;
    qtl_token_t tok0;
    qtl_token_t tok1;
  } qtl_emit_t;

endpackage

// ----- rtl/qtl_if.sv -----
// ----------------------------------------------------------------------------
// qtl_in_if / qtl_out_if
// Valid/ready stream channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface qtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface qtl_out_if
  import qtl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [BYTES_W-1:0] token_bytes;
  logic               last_of_run;

  modport source (output valid, output token_kind, output token_bytes,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_bytes,
                  input last_of_run, output ready);
endinterface

// ----- rtl/qtl_step.sv -----
// ----------------------------------------------------------------------------
// qtl_step
// Next-state and token logic of the lexer for one input byte.
// ----------------------------------------------------------------------------
module qtl_step
  import qtl_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic [7:0]              byte_i,
  input  logic                    eot_i,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [LENGTH_WIDTH-1:0] len_i,
  output logic [MODE_W-1:0]       mode_o,
  output logic [LENGTH_WIDTH-1:0] len_o,
  output qtl_emit_t               emit_o
);

  // Clamp an open length to the 16-bit token field.
  function automatic logic [BYTES_W-1:0] sat_bytes(input logic [LENGTH_WIDTH-1:0] len);
    logic [32:0] wide;
    wide = 33'(len);
    return (wide > 33'h0_ffff) ? {BYTES_W{1'b1}} : wide[BYTES_W-1:0];
  endfunction

  logic                    fin;
  logic                    blank;
  logic [LENGTH_WIDTH-1:0] len_grow;
  logic [MODE_W-1:0]       bg_mode;
  logic [LENGTH_WIDTH-1:0] bg_len;
  logic                    bg_vld;
  logic                    a_vld;
  logic [KIND_W-1:0]       a_kind;
  logic [LENGTH_WIDTH-1:0] a_len;
  logic                    b_vld;
  logic [KIND_W-1:0]       b_kind;
  logic [LENGTH_WIDTH-1:0] b_len;
  qtl_token_t              tok_a;
  qtl_token_t              tok_b;

  assign fin      = eot_i || (byte_i == CHAR_NUL);
  assign blank    = (byte_i == CHAR_SPACE) || (byte_i == CHAR_TAB) || (byte_i == CHAR_CR);
  assign len_grow = (&len_i) ? len_i : len_i + LENGTH_WIDTH'(1);

  // A byte that opens a new token; a lone LF is a complete newline token.
  always_comb begin
    bg_vld = 1'b0;
    bg_len = LENGTH_WIDTH'(1);
    if (byte_i == CHAR_LF) begin
      bg_vld  = 1'b1;
      bg_mode = MODE_IDLE;
      bg_len  = '0;
    end else if (byte_i == CHAR_CR) begin
      bg_mode = MODE_CR;
    end else if ((byte_i == CHAR_SPACE) || (byte_i == CHAR_TAB)) begin
      bg_mode = MODE_WS;
    end else if (byte_i == CHAR_QUOTE) begin
      bg_mode = MODE_STR;
    end else begin
      bg_mode = MODE_WORD;
    end
  end

  // Slot a carries a token that closes, slot b the newline or end token after it.
  always_comb begin
    mode_o = mode_i;
    len_o  = len_i;
    a_vld  = 1'b0;
    a_kind = KIND_SPACE;
    a_len  = len_i;
    b_vld  = 1'b0;
    b_kind = KIND_NEWLINE;
    b_len  = LENGTH_WIDTH'(1);
    if (fin) begin
      unique case (mode_i)
        MODE_CR, MODE_WS: begin
          a_vld  = 1'b1;
          a_kind = KIND_SPACE;
        end
        MODE_WORD: begin
          a_vld  = 1'b1;
          a_kind = KIND_WORD;
        end
        MODE_STR, MODE_ESC: begin
          a_vld  = 1'b1;
          a_kind = KIND_ERROR;
        end
        default: begin
          a_vld = 1'b0;
        end
      endcase
      b_vld  = 1'b1;
      b_kind = KIND_END;
      b_len  = '0;
      mode_o = MODE_IDLE;
      len_o  = '0;
    end else begin
      unique case (mode_i)
        MODE_CR: begin
          if (byte_i == CHAR_LF) begin
            a_vld  = 1'b1;
            a_kind = KIND_NEWLINE;
            a_len  = LENGTH_WIDTH'(2);
            mode_o = MODE_IDLE;
            len_o  = '0;
          end else if (blank) begin
            mode_o = MODE_WS;
            len_o  = len_grow;
          end else begin
            a_vld  = 1'b1;
            a_kind = KIND_SPACE;
            b_vld  = bg_vld;
            mode_o = bg_mode;
            len_o  = bg_len;
          end
        end
        MODE_WS: begin
          if (blank) begin
            len_o = len_grow;
          end else begin
            a_vld  = 1'b1;
            a_kind = KIND_SPACE;
            b_vld  = bg_vld;
            mode_o = bg_mode;
            len_o  = bg_len;
          end
        end
        MODE_WORD: begin
          if (blank || (byte_i == CHAR_LF) || (byte_i == CHAR_QUOTE)) begin
            a_vld  = 1'b1;
            a_kind = KIND_WORD;
            b_vld  = bg_vld;
            mode_o = bg_mode;
            len_o  = bg_len;
          end else begin
            len_o = len_grow;
          end
        end
        MODE_STR: begin
          a_len = len_grow;
          len_o = len_grow;
          if ((byte_i == CHAR_CR) || (byte_i == CHAR_LF)) begin
            a_vld  = 1'b1;
            a_kind = KIND_ERROR;
            mode_o = MODE_IDLE;
            len_o  = '0;
          end else if (byte_i == CHAR_BSL) begin
            mode_o = MODE_ESC;
          end else if (byte_i == CHAR_QUOTE) begin
            a_vld  = 1'b1;
            a_kind = KIND_STRING;
            mode_o = MODE_IDLE;
            len_o  = '0;
          end
        end
        MODE_ESC: begin
          len_o  = len_grow;
          mode_o = MODE_STR;
        end
        default: begin
          b_vld  = bg_vld;
          mode_o = bg_mode;
          len_o  = bg_len;
        end
      endcase
    end
  end

  // Pack the tokens so that the first one always sits in tok0.
  always_comb begin
    tok_a.kind  = a_kind;
    tok_a.bytes = sat_bytes(a_len);
    tok_a.last  = !b_vld;
    tok_b.kind  = b_kind;
    tok_b.bytes = sat_bytes(b_len);
    tok_b.last  = 1'b1;
    if (a_vld) begin
      emit_o.cnt  = b_vld ? 2'd2 : 2'd1;
      emit_o.tok0 = tok_a;
      emit_o.tok1 = tok_b;
    end else begin
      emit_o.cnt  = b_vld ? 2'd1 : 2'd0;
      emit_o.tok0 = tok_b;
      emit_o.tok1 = tok_b;
    end
  end

endmodule

// ----- rtl/qtl_fifo.sv -----
// ----------------------------------------------------------------------------
// qtl_fifo
// Four-entry token queue that takes up to two tokens a cycle and hands
// out one token a cycle while the reader is ready.
// ----------------------------------------------------------------------------
`include "quoted_token_lexer_unit_macros.svh"

module qtl_fifo
  import qtl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  qtl_emit_t push_i,
  output logic      space_o,
  qtl_out_if.source out_o
);

  qtl_token_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W-1:0] rd_ptr_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             pop;

  assign pop     = out_o.valid && out_o.ready;
  // Room for the worst case of two tokens, without counting a pop this cycle.
  assign space_o = (count_q <= CNT_W'(FIFO_DEPTH - 2));

  assign out_o.valid       = (count_q != '0);
  assign out_o.token_kind  = mem_q[rd_ptr_q].kind;
  assign out_o.token_bytes = mem_q[rd_ptr_q].bytes;
  assign out_o.last_of_run = mem_q[rd_ptr_q].last;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `QTL_ASSERT(a_count_bound, count_q <= CNT_W'(FIFO_DEPTH), "token queue overfilled")
  `QTL_ASSERT(a_push_room, (push_i.cnt == 2'd0) || space_o, "tokens pushed without room")
  `QTL_ASSERT_NEXT(a_stall_holds, out_o.valid && !out_o.ready, $stable(rd_ptr_q) && (count_q >= $past(count_q)), "stalled token lost")
  `QTL_ASSERT(a_ptr_count, PTR_W'(wr_ptr_q - rd_ptr_q) == PTR_W'(count_q), "queue pointers disagree with count")

endmodule

// ----- rtl/quoted_token_lexer_unit.sv -----
// A byte accepted from in_i waits in the input stage register and is handed to the token queue
// once the queue has room for both of its tokens; its first token is valid on out_o from then on.
// Throughput: one byte per cycle while tokens drain; a byte makes up to two tokens and the
// four-entry token queue paces the input when the output side stalls.
// Reset: asynchronous, active low; the lexer returns to between tokens with a zero length
// and the input stage and token queue are emptied.
// ----------------------------------------------------------------------------
// quoted_token_lexer_unit
// Streaming tokenizer: one text byte per item in, tokens with kind and length out.
// ----------------------------------------------------------------------------
module quoted_token_lexer_unit
  import qtl_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qtl_in_if.sink    in_i,
  qtl_out_if.source out_o
);

  logic                    stage_vld_q;
  logic [7:0]              stage_byte_q;
  logic                    stage_eot_q;
  logic [MODE_W-1:0]       mode_q;
  logic [MODE_W-1:0]       mode_d;
  logic [LENGTH_WIDTH-1:0] len_q;
  logic [LENGTH_WIDTH-1:0] len_d;
  qtl_emit_t               emit;
  qtl_emit_t               push;
  logic                    space;
  logic                    advance;

  // The staged byte moves on when the queue can take both of its tokens.
  assign advance    = stage_vld_q && space;
  assign in_i.ready = !stage_vld_q || advance;

  qtl_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .byte_i (stage_byte_q),
    .eot_i  (stage_eot_q),
    .mode_i (mode_q),
    .len_i  (len_q),
    .mode_o (mode_d),
    .len_o  (len_d),
    .emit_o (emit)
  );

  always_comb begin
    push     = emit;
    push.cnt = advance ? emit.cnt : 2'd0;
  end

  qtl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stage_byte_q <= in_i.text_byte;
      stage_eot_q  <= in_i.end_of_text;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      len_q       <= '0;
    end else begin
      if (in_i.ready) begin
        stage_vld_q <= in_i.valid;
      end
      if (advance) begin
        mode_q <= mode_d;
        len_q  <= len_d;
      end
    end
  end

endmodule

// ----- tb/sv/quoted_token_lexer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// quoted_token_lexer_unit_tb
// Feeds text bytes into the lexer, predicts each token from its own copy of
// the lexer state and compares every token that comes out, field by field.
// A short directed sequence comes first. Random phrases follow, along with a
// longer bareword and a longer string. Both sides idle at random.
// ----------------------------------------------------------------------------
module quoted_token_lexer_unit_tb;
  import qtl_pkg::*;

  // The open length is as wide as token_bytes here, so both saturate together.
  localparam int unsigned LEN_W           = BYTES_W;
  localparam int unsigned LONG_RUN        = 40;
  localparam int unsigned RANDOM_ITEMS    = 730;
  localparam int unsigned CALM_FROM       = 100;
  localparam int unsigned CALM_TO         = 260;
  localparam int unsigned RX_STALL_AT     = 300;
  localparam int unsigned RX_STALL_CYCLES = 150;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned REPORT_CAP      = 40;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       drain_first;
  } text_item_t;

  logic clk_i;
  logic rst_ni;

  qtl_in_if  in_bus ();
  qtl_out_if out_bus ();

  quoted_token_lexer_unit #(
    .LENGTH_WIDTH(LEN_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Lexer state as the testbench sees it.
  logic [MODE_W-1:0] lex_mode = MODE_IDLE;
  logic [LEN_W-1:0]  open_len = '0;

  qtl_token_t pending_tokens[$];
  text_item_t text_feed[$];
  logic       drain_next = 1'b0;

  int errors      = 0;
  int tokens_seen = 0;
  int bytes_taken = 0;
  int tx_cycle    = 0;
  int rx_cycle    = 0;
  int hold_left   = 0;
  int quiet       = 0;
  int kind_seen[8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic qtl_token_t token_of(input logic [KIND_W-1:0] kind,
                                          input logic [LEN_W-1:0] len);
    qtl_token_t t;
    t.kind  = kind;
    t.bytes = len;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic void grow_run();
    if (open_len != '1) open_len = open_len + 1'b1;
  endfunction

  // Advances the lexer state by one byte and queues the tokens it completes.
  function automatic void lex_byte(input logic [7:0] b, input logic eot);
    qtl_token_t made[$];
    logic       fin;
    logic       blank;
    logic       reopen;
    fin    = eot || (b == CHAR_NUL);
    blank  = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR);
    reopen = 1'b0;
    if (fin) begin
      case (lex_mode)
        MODE_CR, MODE_WS: made.push_back(token_of(KIND_SPACE, open_len));
        MODE_WORD:        made.push_back(token_of(KIND_WORD, open_len));
        MODE_STR, MODE_ESC: made.push_back(token_of(KIND_ERROR, open_len));
        default: ;
      endcase
      made.push_back(token_of(KIND_END, '0));
      lex_mode = MODE_IDLE;
      open_len = '0;
    end else begin
      case (lex_mode)
        MODE_CR: begin
          if (b == CHAR_LF) begin
            made.push_back(token_of(KIND_NEWLINE, LEN_W'(2)));
            lex_mode = MODE_IDLE;
            open_len = '0;
          end else if (blank) begin
            lex_mode = MODE_WS;
            grow_run();
          end else begin
            made.push_back(token_of(KIND_SPACE, open_len));
            reopen = 1'b1;
          end
        end
        MODE_WS: begin
          if (blank) begin
            grow_run();
          end else begin
            made.push_back(token_of(KIND_SPACE, open_len));
            reopen = 1'b1;
          end
        end
        MODE_WORD: begin
          if (blank || b == CHAR_LF || b == CHAR_QUOTE) begin
            made.push_back(token_of(KIND_WORD, open_len));
            reopen = 1'b1;
          end else begin
            grow_run();
          end
        end
        MODE_STR: begin
          grow_run();
          if (b == CHAR_CR || b == CHAR_LF) begin
            made.push_back(token_of(KIND_ERROR, open_len));
            lex_mode = MODE_IDLE;
            open_len = '0;
          end else if (b == CHAR_BSL) begin
            lex_mode = MODE_ESC;
          end else if (b == CHAR_QUOTE) begin
            made.push_back(token_of(KIND_STRING, open_len));
            lex_mode = MODE_IDLE;
            open_len = '0;
          end
        end
        MODE_ESC: begin
          grow_run();
          lex_mode = MODE_STR;
        end
        default: reopen = 1'b1;
      endcase
      if (reopen) begin
        open_len = LEN_W'(1);
        case (b)
          CHAR_LF: begin
            made.push_back(token_of(KIND_NEWLINE, LEN_W'(1)));
            lex_mode = MODE_IDLE;
            open_len = '0;
          end
          CHAR_CR:              lex_mode = MODE_CR;
          CHAR_SPACE, CHAR_TAB: lex_mode = MODE_WS;
          CHAR_QUOTE:           lex_mode = MODE_STR;
          default:              lex_mode = MODE_WORD;
        endcase
      end
    end
    foreach (made[i]) begin
      made[i].last = (i == made.size() - 1);
      pending_tokens.push_back(made[i]);
    end
  endfunction

  function automatic void send(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.text_byte   = b;
    it.end_of_text = eot;
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    text_feed.push_back(it);
  endfunction

  // Any byte that may sit inside a bareword.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF ||
           b == CHAR_QUOTE);
    return b;
  endfunction

  // Mostly well-formed tokens, with broken strings, stray bytes and ends mixed in.
  function automatic void add_phrase();
    int         pick;
    int         ending;
    logic [7:0] b;
    pick = $urandom_range(99);
    if ($urandom_range(99) == 0) drain_next = 1'b1;
    if (pick < 30) begin
      repeat ($urandom_range(1, 8)) send(plain_byte(), 1'b0);
    end else if (pick < 45) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(2))
          0:       send(CHAR_SPACE, 1'b0);
          1:       send(CHAR_TAB, 1'b0);
          default: send(CHAR_CR, 1'b0);
        endcase
      end
    end else if (pick < 55) begin
      if ($urandom_range(1)) send(CHAR_CR, 1'b0);
      send(CHAR_LF, 1'b0);
    end else if (pick < 80) begin
      send(CHAR_QUOTE, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        b = plain_byte();
        send(b, 1'b0);
        // A backslash takes the next byte whatever it is.
        if (b == CHAR_BSL) send(8'($urandom_range(1, 255)), 1'b0);
      end
      ending = $urandom_range(9);
      if (ending < 7)       send(CHAR_QUOTE, 1'b0);
      else if (ending == 7) send($urandom_range(1) ? CHAR_CR : CHAR_LF, 1'b0);
      else if (ending == 8) send(8'($urandom_range(255)), 1'b1);
    end else if (pick < 92) begin
      send(8'($urandom_range(255)), 1'b0);
    end else if (pick < 97) begin
      send(8'($urandom_range(255)), 1'b1);
    end else begin
      send(CHAR_NUL, 1'b0);
    end
  endfunction

  function automatic void report(input string field, input int want, input int got);
    errors++;
    if (errors <= REPORT_CAP)
      $display("%0t: token %0d %s mismatch: expected %0d, actual %0d",
               $time, tokens_seen, field, want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : tx_drive
    logic gap;
    if (!rst_ni) begin
      in_bus.valid       <= 1'b0;
      in_bus.text_byte   <= '0;
      in_bus.end_of_text <= 1'b0;
    end else begin
      tx_cycle++;
      if (in_bus.valid && in_bus.ready) begin
        lex_byte(in_bus.text_byte, in_bus.end_of_text);
        bytes_taken++;
      end
      gap = ($urandom_range(99) < 8) && !(tx_cycle >= CALM_FROM && tx_cycle < CALM_TO);
      if (!in_bus.valid || in_bus.ready) begin
        if (text_feed.size() != 0 && !gap &&
            !(text_feed[0].drain_first && pending_tokens.size() != 0)) begin
          in_bus.valid       <= 1'b1;
          in_bus.text_byte   <= text_feed[0].text_byte;
          in_bus.end_of_text <= text_feed[0].end_of_text;
          void'(text_feed.pop_front());
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : rx_check
    qtl_token_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_bus.valid && out_bus.ready) begin
        tokens_seen++;
        if (pending_tokens.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected token: expected none, actual kind %0d bytes %0d last %0b",
                     $time, out_bus.token_kind, out_bus.token_bytes, out_bus.last_of_run);
        end else begin
          want = pending_tokens.pop_front();
          kind_seen[want.kind]++;
          if (out_bus.token_kind !== want.kind)
            report("kind", int'(want.kind), int'(out_bus.token_kind));
          if (out_bus.token_bytes !== want.bytes)
            report("bytes", int'(want.bytes), int'(out_bus.token_bytes));
          if (out_bus.last_of_run !== want.last)
            report("last", int'(want.last), int'(out_bus.last_of_run));
        end
      end
      // One long hold-off lets the token queue fill and push back on the input.
      if (rx_cycle == RX_STALL_AT) hold_left = RX_STALL_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(($urandom_range(99) < 8) &&
                           !(rx_cycle >= CALM_FROM && rx_cycle < CALM_TO));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles", $time, quiet);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int base;
    in_bus.valid       = 1'b0;
    in_bus.text_byte   = '0;
    in_bus.end_of_text = 1'b0;
    out_bus.ready      = 1'b0;

    // Bareword closed by a quote, then a string holding an escaped quote.
    send("a", 1'b0); send("b", 1'b0); send(CHAR_QUOTE, 1'b0);
    send(CHAR_BSL, 1'b0); send(CHAR_QUOTE, 1'b0); send("x", 1'b0); send(CHAR_QUOTE, 1'b0);
    // CR LF newline, then a lone CR ahead of a bareword byte.
    send(CHAR_CR, 1'b0); send(CHAR_LF, 1'b0);
    send(CHAR_CR, 1'b0); send("q", 1'b0);
    // Whitespace run ended by LF gives two tokens for one byte.
    send(CHAR_SPACE, 1'b0); send(CHAR_TAB, 1'b0); send(CHAR_CR, 1'b0); send(CHAR_LF, 1'b0);
    // High bytes in a bareword; CR inside a string is an error.
    send(8'hff, 1'b0); send(8'h80, 1'b0); send(CHAR_QUOTE, 1'b0); send(CHAR_CR, 1'b0);
    // End flag inside a string, zero byte after a backslash, end with nothing open.
    send(CHAR_QUOTE, 1'b0); send("b", 1'b0); send(8'ha5, 1'b1);
    send(CHAR_QUOTE, 1'b0); send(CHAR_BSL, 1'b0); send(CHAR_NUL, 1'b0);
    send(8'h5a, 1'b1);
    // Lone CR closed by the end flag, then a bareword closed by a zero byte.
    send(CHAR_CR, 1'b0); send(8'hff, 1'b1);
    send("w", 1'b0); send(CHAR_NUL, 1'b0);

    drain_next = 1'b1;
    base = text_feed.size();
    while (text_feed.size() < base + RANDOM_ITEMS / 2) add_phrase();

    // A longer bareword and a longer string.
    drain_next = 1'b1;
    send(CHAR_LF, 1'b0);
    repeat (LONG_RUN) send("k", 1'b0);
    send(CHAR_SPACE, 1'b0);
    send(CHAR_QUOTE, 1'b0);
    repeat (LONG_RUN) send("s", 1'b0);
    send(CHAR_QUOTE, 1'b0);

    base = text_feed.size();
    while (text_feed.size() < base + RANDOM_ITEMS / 2) add_phrase();
    send(8'h00, 1'b1);

    while (text_feed.size() != 0 || in_bus.valid !== 1'b0) @(posedge clk_i);
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Lexed %0d bytes into %0d tokens: %0d strings, %0d barewords, %0d newlines,",
             bytes_taken, tokens_seen, kind_seen[KIND_STRING], kind_seen[KIND_WORD],
             kind_seen[KIND_NEWLINE]);
    $display("%0d blank runs, %0d errors, %0d ends; a bareword and a string of %0d bytes each.",
             kind_seen[KIND_SPACE], kind_seen[KIND_ERROR], kind_seen[KIND_END], LONG_RUN);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qtl_pkg.sv
rtl/qtl_if.sv
rtl/qtl_step.sv
rtl/qtl_fifo.sv
rtl/quoted_token_lexer_unit.sv
tb/sv/quoted_token_lexer_unit_tb.sv
